// File: rtl/ebb_pkg.sv
`default_nettype none

package ebb_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxRadius  = 3;
  localparam int SampleBits = 16;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowSlots   = 2 * MaxRadius + 2;
  localparam int SlotBits   = $clog2(RowSlots);
  localparam int StoreDepth = (1 << SlotBits) * MaxWidth;
  localparam int SizeBits   = 11;
  localparam int RadBits    = 2;
  localparam int SumBits    = 22;
  localparam int CntBits    = 6;
  localparam int PendBits   = 2 * ColBits + 1;
  localparam int DelayBits  = 12;
  localparam int DivCntBits = 5;

  localparam logic [1:0] CfgImageSize = 2'd0;
  localparam logic [1:0] CfgRadius    = 2'd1;

  localparam logic FuncSample = 1'b0;
  localparam logic FuncFlush  = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [SampleBits-1:0] height_in;
  } in_item_t;

  typedef struct packed {
    logic [SampleBits-1:0] height_out;
    logic                  frame_end;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic setup;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ebb_cmd_t;

  typedef struct packed {
    logic emit;
    logic sum_last;
    logic div_last;
    logic out_free;
  } ebb_sts_t;

endpackage

`default_nettype wire

// File: rtl/ebb_ram.sv
`default_nettype none

module ebb_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/ebb_ctrl.sv
`default_nettype none

module ebb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ebb_pkg::ebb_sts_t sts_i,
  output ebb_pkg::ebb_cmd_t  cmd_o
);
  import ebb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_SETUP, S_SUM, S_ACC, S_DIVINIT, S_DIV, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.emit ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = stall_q;

  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_EVAL)
    else $error("capture did not lead to evaluation");
  a_out_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> !in_stall_o)
    else $error("block still stalled after result load");
  a_sum_before_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> $past(cmd_o.sum_step))
    else $error("accumulate stage not preceded by a read");

endmodule

`default_nettype wire

// File: rtl/ebb_dp.sv
`default_nettype none

module ebb_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [ebb_pkg::SizeBits-1:0] cfg_data_i,
  input  wire ebb_pkg::in_item_t            in_item_i,
  output ebb_pkg::out_item_t                out_item_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  input  wire ebb_pkg::ebb_cmd_t            cmd_i,
  output ebb_pkg::ebb_sts_t                 sts_o
);
  import ebb_pkg::*;

  localparam int AddrBits = $clog2(StoreDepth);

  logic [SizeBits-1:0]   size_q;
  logic [RadBits-1:0]    radius_q;
  logic [SizeBits-1:0]   n_eff;
  logic [SizeBits-1:0]   n_q;
  logic [RadBits-1:0]    r_q;
  logic [DelayBits-1:0]  delay_q, delay_d;
  logic                  active_q;
  in_item_t              item_q;
  logic [ColBits-1:0]    in_col_q, out_col_q, out_row_q;
  logic [SizeBits-1:0]   in_row_q;
  logic [PendBits-1:0]   pend_q, pend_inc;
  logic                  row_ok, emit_s, sample, wr_en;
  logic [ColBits-1:0]    nm1;
  logic [ColBits-1:0]    r0, r1, c0, c1;
  logic [ColBits-1:0]    r1_q, c0_q, c1_q, y_q, x_q;
  logic [2:0]            span_r, span_c;
  logic [CntBits-1:0]    count_q;
  logic                  last_q, rd_vld_q;
  logic [SumBits-1:0]    sum_q, quo_q;
  logic [CntBits-1:0]    rem_q;
  logic [CntBits:0]      rem2, diff;
  logic [DivCntBits-1:0] div_cnt_q;
  logic [SampleBits-1:0] rdata;
  logic                  out_valid_q;

  always_comb begin
    if (size_q == '0) begin
      n_eff = SizeBits'(1);
    end else if (size_q > SizeBits'(MaxWidth)) begin
      n_eff = SizeBits'(MaxWidth);
    end else begin
      n_eff = size_q;
    end
    delay_d = DelayBits'({{(DelayBits-RadBits){1'b0}}, radius_q}
                         * {{(DelayBits-SizeBits){1'b0}}, n_eff})
              + DelayBits'(radius_q);
  end

  assign sample   = (item_q.func == FuncSample);
  assign row_ok   = in_row_q < n_q;
  assign pend_inc = pend_q + PendBits'(1);
  assign emit_s   = sample ? (row_ok && (pend_inc > PendBits'(delay_q)))
                           : (active_q && !row_ok);
  assign wr_en    = cmd_i.eval && sample && row_ok;

  assign nm1 = ColBits'(n_q - SizeBits'(1));

  always_comb begin
    r0 = (out_row_q >= ColBits'(r_q)) ? out_row_q - ColBits'(r_q) : '0;
    c0 = (out_col_q >= ColBits'(r_q)) ? out_col_q - ColBits'(r_q) : '0;
    r1 = (({1'b0, out_row_q} + SizeBits'(r_q)) < {1'b0, nm1})
         ? out_row_q + ColBits'(r_q) : nm1;
    c1 = (({1'b0, out_col_q} + SizeBits'(r_q)) < {1'b0, nm1})
         ? out_col_q + ColBits'(r_q) : nm1;
    span_r = 3'(r1 - r0 + ColBits'(1));
    span_c = 3'(c1 - c0 + ColBits'(1));
  end

  assign rem2 = {rem_q, quo_q[SumBits-1]};
  assign diff = rem2 - {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeBits'(MaxWidth);
      radius_q    <= RadBits'(1);
      n_q         <= SizeBits'(MaxWidth);
      r_q         <= RadBits'(1);
      delay_q     <= '0;
      active_q    <= 1'b0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      pend_q      <= '0;
      rd_vld_q    <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CfgImageSize) begin
        size_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CfgRadius) begin
        radius_q <= cfg_data_i[RadBits-1:0];
      end
      if (!active_q) begin
        n_q     <= n_eff;
        r_q     <= radius_q;
        delay_q <= delay_d;
      end
      if (cmd_i.eval && sample) begin
        active_q <= 1'b1;
        if (row_ok) begin
          if (({1'b0, in_col_q} + SizeBits'(1)) >= n_q) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + SizeBits'(1);
          end else begin
            in_col_q <= in_col_q + ColBits'(1);
          end
          if (!emit_s) begin
            pend_q <= pend_inc;
          end
        end
      end
      rd_vld_q <= cmd_i.sum_step;
      if (cmd_i.div_init) begin
        div_cnt_q <= DivCntBits'(SumBits - 1);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DivCntBits'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        if (last_q) begin
          active_q  <= 1'b0;
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          pend_q    <= '0;
        end else if (out_col_q == nm1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ColBits'(1);
        end else begin
          out_col_q <= out_col_q + ColBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.setup) begin
      r1_q    <= r1;
      c0_q    <= c0;
      c1_q    <= c1;
      y_q     <= r0;
      x_q     <= c0;
      count_q <= CntBits'(span_r) * CntBits'(span_c);
      last_q  <= (out_row_q == nm1) && (out_col_q == nm1);
      sum_q   <= '0;
    end else begin
      if (cmd_i.sum_step) begin
        if (x_q == c1_q) begin
          x_q <= c0_q;
          y_q <= y_q + ColBits'(1);
        end else begin
          x_q <= x_q + ColBits'(1);
        end
      end
      if (rd_vld_q) begin
        sum_q <= sum_q + SumBits'(rdata);
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      if (rem2 >= {1'b0, count_q}) begin
        rem_q <= diff[CntBits-1:0];
        quo_q <= {quo_q[SumBits-2:0], 1'b1};
      end else begin
        rem_q <= rem2[CntBits-1:0];
        quo_q <= {quo_q[SumBits-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_item_o.height_out <= quo_q[SampleBits-1:0];
      out_item_o.frame_end  <= last_q;
    end
  end

  ebb_ram #(
    .Width(SampleBits),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i({in_row_q[SlotBits-1:0], in_col_q}),
    .wdata_i(item_q.height_in),
    .raddr_i(AddrBits'({y_q[SlotBits-1:0], x_q})),
    .rdata_o(rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign sts_o.emit     = emit_s;
  assign sts_o.sum_last = (x_q == c1_q) && (y_q == r1_q);
  assign sts_o.div_last = (div_cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  a_no_write_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum_step |-> !wr_en)
    else $error("row store written while the window is read");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.setup |=> count_q != '0)
    else $error("window count is zero");
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && last_q) |=> !active_q && pend_q == '0)
    else $error("frame not closed after its last pixel");

endmodule

`default_nettype wire

// File: rtl/edge_normalized_box_blur.sv
// An item that yields a result passes window setup, the window sum, the divider and
// the result load; the sum covers count (1 to 49) window pixels inside the map.
// The block takes one item at a time and stalls further input until it is done.
// The window sum reads one row store entry per cycle through the single read port,
// and the mean comes from a 22-step restoring divider.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module edge_normalized_box_blur (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ebb_pkg::in_item_t            in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ebb_pkg::out_item_t                out_item_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [ebb_pkg::SizeBits-1:0] cfg_data_i
);
  import ebb_pkg::*;

  ebb_cmd_t cmd;
  ebb_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ebb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ebb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

// File: test/tb_edge_normalized_box_blur.sv
`default_nettype none

module tb_edge_normalized_box_blur;
  timeunit 1ns;
  timeprecision 1ps;
  import ebb_pkg::*;

  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 100;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_item_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [SizeBits-1:0] cfg_data_i;

  edge_normalized_box_blur dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  in_item_t pixel_queue[$];
  out_item_t mean_queue[$];
  int errors = 0;
  int cycles = 0;

  // Blur state as seen from outside.
  logic [SampleBits-1:0] line_mem[RowSlots][MaxWidth];
  int unsigned wr_col, wr_row, rd_col, rd_row;
  int unsigned size_reg, rad_reg, frame_n, frame_r;
  bit in_frame;

  function automatic int unsigned clamp_size(int unsigned v);
    if (v < 1) return 1;
    if (v > MaxWidth) return MaxWidth;
    return v;
  endfunction

  task automatic emit_mean();
    int unsigned y0, y1, x0, x1, cnt, acc;
    bit last;
    out_item_t res;
    y0 = (rd_row >= frame_r) ? rd_row - frame_r : 0;
    y1 = (rd_row + frame_r < frame_n - 1) ? rd_row + frame_r : frame_n - 1;
    x0 = (rd_col >= frame_r) ? rd_col - frame_r : 0;
    x1 = (rd_col + frame_r < frame_n - 1) ? rd_col + frame_r : frame_n - 1;
    cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
    last = (rd_row == frame_n - 1) && (rd_col == frame_n - 1);
    acc = 0;
    for (int unsigned y = y0; y <= y1; y++)
      for (int unsigned x = x0; x <= x1; x++)
        acc += line_mem[y % RowSlots][x];
    res.height_out = SampleBits'(acc / cnt);
    res.frame_end = last;
    mean_queue = {mean_queue, res};
    if (last) begin
      in_frame = 0;
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    end else begin
      rd_col++;
      if (rd_col >= frame_n) begin
        rd_col = 0;
        rd_row++;
      end
    end
  endtask

  task automatic blur_step(in_item_t it);
    if (it.func == FuncSample) begin
      if (!in_frame) begin
        frame_n = clamp_size(size_reg);
        frame_r = (rad_reg > MaxRadius) ? MaxRadius : rad_reg;
        in_frame = 1;
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
      end
      if (wr_row >= frame_n) return;
      line_mem[wr_row % RowSlots][wr_col] = it.height_in;
      wr_col++;
      if (wr_col >= frame_n) begin
        wr_col = 0;
        wr_row++;
      end
      if ((wr_row * frame_n + wr_col) - (rd_row * frame_n + rd_col)
          > frame_r * frame_n + frame_r)
        emit_mean();
    end else if (in_frame && wr_row >= frame_n) begin
      emit_mean();
    end
  endtask

  initial begin
    clk_i = 0;
  end
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    bit held;
    if (rst_ni) begin
      held = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o)
        blur_step(pixel_queue.pop_front());
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 0;
        end else if (pixel_queue.size() > 0) begin
          in_valid_i <= 1;
          in_item_i <= pixel_queue[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Receiver: stall pattern switching between calm, light and heavy modes.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1;
    end else if (stall_mode == 1) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 20);
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mean_queue.size() == 0) begin
        $error("unexpected item: height_out %h frame_end %b",
               out_item_o.height_out, out_item_o.frame_end);
        errors++;
      end else begin
        want = mean_queue.pop_front();
        if (out_item_o.height_out !== want.height_out) begin
          $error("height_out: expected %h, got %h", want.height_out, out_item_o.height_out);
          errors++;
        end
        if (out_item_o.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_item_o.frame_end);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [SizeBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    if (idx == CfgImageSize) size_reg = val;
    else if (idx == CfgRadius) rad_reg = val[RadBits-1:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || mean_queue.size() != 0 || in_valid_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [SampleBits-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return SampleBits'($urandom());
    endcase
  endfunction

  task automatic push_item(logic f, logic [SampleBits-1:0] h);
    in_item_t it;
    it.func = f;
    it.height_in = h;
    pixel_queue = {pixel_queue, it};
  endtask

  // One whole frame at the current register values, optionally with
  // stray flushes and surplus samples mixed in.
  task automatic push_frame(bit noisy, inout int count);
    int unsigned n, r, lag;
    int base;
    base = pixel_queue.size();
    n = clamp_size(size_reg);
    r = (rad_reg > MaxRadius) ? MaxRadius : rad_reg;
    lag = r * n + r;
    for (int unsigned i = 0; i < n * n; i++) begin
      push_item(FuncSample, pick_height());
      if (noisy && i + 1 < n * n && $urandom_range(0, 9) == 0) push_item(FuncFlush, pick_height());
    end
    if (noisy) repeat ($urandom_range(1, 2)) push_item(FuncSample, pick_height());
    repeat ((lag < n * n) ? lag : n * n) push_item(FuncFlush, pick_height());
    if (noisy) push_item(FuncFlush, pick_height());
    count += pixel_queue.size() - base;
  endtask

  initial begin
    int sent;
    int unsigned sz;
    rst_ni = 0;
    in_valid_i = 0;
    in_item_i = '0;
    out_stall_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = CfgImageSize;
    cfg_data_i = '0;
    size_reg = MaxWidth;
    rad_reg = 1;
    in_frame = 0;
    wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    write_reg(CfgImageSize, 11'h7FF);
    write_reg(CfgImageSize, 11'd1024);
    write_reg(CfgSpareA, 11'h7FF);
    write_reg(CfgSpareB, 11'h555);
    write_reg(CfgImageSize, 11'd0);
    write_reg(CfgRadius, 11'd3);
    push_item(FuncFlush, 16'hFFFF);
    push_item(FuncSample, 16'hFFFF);
    push_item(FuncFlush, 16'h0000);
    push_item(FuncSample, 16'h1234);
    push_item(FuncFlush, 16'h0000);
    push_item(FuncFlush, 16'h0000);
    wait_drained();

    write_reg(CfgImageSize, 11'd2);
    write_reg(CfgRadius, 11'd0);
    push_item(FuncSample, 16'h0000);
    push_item(FuncSample, 16'hFFFF);
    push_item(FuncSample, 16'h8000);
    push_item(FuncSample, 16'h7FFF);
    wait_drained();

    write_reg(CfgImageSize, 11'd3);
    write_reg(CfgRadius, 11'd1);
    push_frame(1, sent);
    wait_drained();

    while (sent < 1050) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 6);
      write_reg(CfgImageSize, SizeBits'(sz));
      write_reg(CfgRadius, SizeBits'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) write_reg(CfgSpareA, SizeBits'($urandom()));
      repeat ($urandom_range(1, 4)) push_frame($urandom_range(0, 3) == 0, sent);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
